FILE: design/apq_pkg.sv
// ----------------------------------------------------------------------------
// apq_pkg: shared types and codes for the aging priority queue
// Operation and status codes plus the controller/datapath command bundles.
// ----------------------------------------------------------------------------
package apq_pkg;

    localparam logic [1:0] OP_PUSH     = 2'd0;
    localparam logic [1:0] OP_POP      = 2'd1;
    localparam logic [1:0] OP_CONTAINS = 2'd2;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_FULL         = 2'd1;
    localparam logic [1:0] ST_BAD_PRIORITY = 2'd2;
    localparam logic [1:0] ST_EMPTY        = 2'd3;

    // datapath commands, at most one set per cycle
    typedef struct packed {
        logic load;        // capture input item
        logic push;        // write item to its level tail
        logic pop_rd;      // issue read of first non-empty level head
        logic pop_fin;     // take the read word, drop head
        logic age_step;    // age the current level, decide promotion
        logic mv_rd;       // read head of lower level
        logic mv_wr;       // append read word to upper level
        logic scan_start;  // begin contains scan
        logic scan_step;   // one entry of the scan
        logic done;        // drive result
    } apq_cmd_t;

    typedef struct packed {
        logic bad_pri;
        logic full;
        logic any_nonempty;
        logic age_last;    // aging walk reached lowest level
        logic promote;     // current level promotes
        logic mv_more;     // more items to move
        logic scan_end;    // scan finished or matched
    } apq_stat_t;

endpackage

FILE: design/apq_ram.sv
// ----------------------------------------------------------------------------
// apq_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module apq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

FILE: design/apq_ctrl.sv
// ----------------------------------------------------------------------------
// apq_ctrl: operation sequencer
// Steps push, pop with aging/promotion and contains scan through the datapath.
// ----------------------------------------------------------------------------
module apq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        operation,
    input  apq_pkg::apq_stat_t stat,
    output apq_pkg::apq_cmd_t  cmd,
    output logic              busy
);
    import apq_pkg::*;

    // item memory has registered read data: a read issued in one state
    // is consumed in the next
    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_POP_FIN, S_AGE,
        S_MV_RD, S_MV_WR, S_SCAN_INIT, S_SCAN, S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] op_reg, op_next;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    op_next    = operation;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (op_reg)
                    OP_PUSH:
                    begin
                        if (!stat.bad_pri && !stat.full)
                        begin
                            cmd.push = 1'b1;
                        end
                        state_next = S_DONE;
                    end
                    OP_POP:
                    begin
                        if (stat.any_nonempty)
                        begin
                            cmd.pop_rd = 1'b1;
                            state_next = S_POP_FIN;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    OP_CONTAINS: state_next = S_SCAN_INIT;
                    default:     state_next = S_DONE;
                endcase
            end
            S_POP_FIN:
            begin
                cmd.pop_fin = 1'b1;
                state_next  = S_AGE;
            end
            S_AGE:
            begin
                if (stat.age_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.age_step = 1'b1;
                    state_next   = stat.promote ? S_MV_RD : S_AGE;
                end
            end
            S_MV_RD:
            begin
                if (stat.mv_more)
                begin
                    cmd.mv_rd  = 1'b1;
                    state_next = S_MV_WR;
                end
                else
                begin
                    state_next = S_AGE;
                end
            end
            S_MV_WR:
            begin
                cmd.mv_wr  = 1'b1;
                state_next = S_MV_RD;
            end
            S_SCAN_INIT:
            begin
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN;
            end
            S_SCAN:
            begin
                if (stat.scan_end)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_DONE:
            begin
                cmd.done   = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_PUSH;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
endmodule

FILE: design/apq_dp.sv
// ----------------------------------------------------------------------------
// apq_dp: queue datapath
// Level pointers, ages, item store and the scan/aging walk registers.
// ----------------------------------------------------------------------------
module apq_dp #(
    parameter int NUM_LEVELS  = 8,
    parameter int LEVEL_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  apq_pkg::apq_cmd_t  cmd,
    output apq_pkg::apq_stat_t stat,
    input  logic [1:0]         operation,
    input  logic [31:0]        item_value,
    input  logic [3:0]         priority_req,
    input  logic [15:0]        age_limit,
    output logic [1:0]         status,
    output logic [31:0]        item_out,
    output logic               found,
    output logic               queue_empty,
    output logic               done
);
    import apq_pkg::*;

    localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int HW = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int CW = $clog2(LEVEL_DEPTH + 1);
    localparam int AW = LW + HW;
    localparam int DEPTH = 1 << AW;

    logic [HW-1:0] head_reg  [NUM_LEVELS];
    logic [CW-1:0] count_reg [NUM_LEVELS];
    logic [15:0]   age_reg   [NUM_LEVELS];

    logic [1:0]    op_reg;
    logic [31:0]   val_reg;
    logic [3:0]    pri_reg;
    logic [LW-1:0] lvl_reg;     // aging walk / scan level
    logic [CW-1:0] k_reg;       // scan index within level
    logic [CW-1:0] mv_reg;      // items left to promote
    logic          hit_reg;
    logic [31:0]   item_reg;
    logic [1:0]    status_reg;
    logic          done_reg;
    logic          rd_pend_reg; // scan read in flight
    logic          promo_idle_reg; // promotion decision found nothing to move

    logic          we;
    logic [AW-1:0] addr;
    logic [31:0]   wdata, rdata;

    apq_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    // first non-empty level
    logic [LW-1:0] first_lvl;
    logic          any_ne;
    always_comb
    begin
        first_lvl = '0;
        any_ne    = 1'b0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (count_reg[i] != '0)
            begin
                first_lvl = LW'(i);
                any_ne    = 1'b1;
            end
        end
    end

    // slot wrap: head + offset stays below twice the depth
    function automatic logic [HW-1:0] wrap(input logic [HW-1:0] h, input logic [CW-1:0] c);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(c);
        if (s >= (CW+1)'(LEVEL_DEPTH))
            s = s - (CW+1)'(LEVEL_DEPTH);
        wrap = HW'(s);
    endfunction

    logic [LW-1:0] pri_l, low_l;
    logic          pri_ok;
    logic          lvl_last;
    logic [15:0]   age_inc;
    logic [CW-1:0] room, nmv;
    assign pri_ok   = (32'(pri_reg) < NUM_LEVELS);
    assign pri_l    = pri_reg[LW-1:0];
    assign low_l    = lvl_reg + LW'(1);
    assign lvl_last = (32'(lvl_reg) + 1 >= NUM_LEVELS);
    assign age_inc  = age_reg[lvl_reg] + 16'd1;
    assign room     = CW'(LEVEL_DEPTH) - count_reg[lvl_reg];
    assign nmv      = (room < count_reg[low_l]) ? room : count_reg[low_l];

    logic scan_lvl_end;
    assign scan_lvl_end = (k_reg >= count_reg[lvl_reg]);

    always_comb
    begin
        we    = 1'b0;
        addr  = '0;
        wdata = val_reg;
        if (cmd.push)
        begin
            we   = 1'b1;
            addr = {pri_l, wrap(head_reg[pri_l], count_reg[pri_l])};
        end
        else if (cmd.pop_rd)
        begin
            addr = {first_lvl, head_reg[first_lvl]};
        end
        else if (cmd.mv_rd)
        begin
            addr = {low_l, head_reg[low_l]};
        end
        else if (cmd.mv_wr)
        begin
            we    = 1'b1;
            wdata = rdata;
            addr  = {lvl_reg, wrap(head_reg[lvl_reg], count_reg[lvl_reg])};
        end
        else if (cmd.scan_step)
        begin
            addr = {lvl_reg, wrap(head_reg[lvl_reg], k_reg)};
        end
    end

    assign stat.bad_pri      = !pri_ok;
    assign stat.full         = pri_ok && (count_reg[pri_l] >= CW'(LEVEL_DEPTH));
    assign stat.any_nonempty = any_ne;
    assign stat.age_last     = lvl_last;
    assign stat.promote      = (age_inc >= age_limit);
    assign stat.mv_more      = (mv_reg != '0);
    assign stat.scan_end     = hit_reg || (!rd_pend_reg && scan_lvl_end && lvl_last);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            val_reg <= item_value;
            pri_reg <= priority_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
                age_reg[i]   <= '0;
            end
            op_reg       <= OP_PUSH;
            lvl_reg      <= '0;
            k_reg        <= '0;
            mv_reg       <= '0;
            hit_reg      <= 1'b0;
            item_reg     <= '0;
            status_reg   <= ST_OK;
            done_reg     <= 1'b0;
            rd_pend_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.done;
            if (cmd.load)
            begin
                op_reg      <= operation;
                item_reg    <= '0;
                hit_reg     <= 1'b0;
                rd_pend_reg <= 1'b0;
                status_reg  <= (operation == OP_POP) ? ST_EMPTY : ST_OK;
            end
            if (op_reg == OP_PUSH && !cmd.load && !cmd.done && !done_reg)
            begin
                status_reg <= !pri_ok ? ST_BAD_PRIORITY
                            : (count_reg[pri_l] >= CW'(LEVEL_DEPTH)) ? ST_FULL : ST_OK;
            end
            if (cmd.push)
            begin
                count_reg[pri_l] <= count_reg[pri_l] + CW'(1);
            end
            if (cmd.pop_rd)
            begin
                lvl_reg    <= first_lvl;
                status_reg <= ST_OK;
            end
            if (cmd.pop_fin)
            begin
                item_reg            <= rdata;
                head_reg[lvl_reg]   <= wrap(head_reg[lvl_reg], CW'(1));
                count_reg[lvl_reg]  <= count_reg[lvl_reg] - CW'(1);
            end
            if (cmd.age_step)
            begin
                if (age_inc >= age_limit)
                begin
                    age_reg[lvl_reg] <= '0;
                    mv_reg           <= nmv;
                end
                else
                begin
                    age_reg[lvl_reg] <= age_inc;
                    lvl_reg          <= lvl_reg + LW'(1);
                end
            end
            if (cmd.mv_rd)
            begin
                head_reg[low_l]  <= wrap(head_reg[low_l], CW'(1));
                count_reg[low_l] <= count_reg[low_l] - CW'(1);
                mv_reg           <= mv_reg - CW'(1);
            end
            if (cmd.mv_wr)
            begin
                count_reg[lvl_reg] <= count_reg[lvl_reg] + CW'(1);
                if (mv_reg == '0)
                begin
                    lvl_reg <= lvl_reg + LW'(1);
                end
            end
            // promotion of zero items: advance walk
            if (!cmd.mv_rd && !cmd.mv_wr && !cmd.age_step && mv_reg == '0
                && !cmd.pop_fin && !cmd.pop_rd && op_reg == OP_POP && promo_idle_reg)
            begin
                lvl_reg <= lvl_reg + LW'(1);
            end
            if (cmd.scan_start)
            begin
                lvl_reg <= '0;
                k_reg   <= '0;
            end
            // compare the word read last cycle, issue the next read
            if (cmd.scan_step)
            begin
                rd_pend_reg <= 1'b0;
                if (rd_pend_reg && rdata == val_reg)
                begin
                    hit_reg <= 1'b1;
                end
                else if (scan_lvl_end)
                begin
                    if (!lvl_last)
                    begin
                        lvl_reg <= lvl_reg + LW'(1);
                        k_reg   <= '0;
                    end
                end
                else
                begin
                    k_reg       <= k_reg + CW'(1);
                    rd_pend_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            promo_idle_reg <= 1'b0;
        end
        else
        begin
            promo_idle_reg <= cmd.age_step && (age_inc >= age_limit) && (nmv == '0);
        end
    end

    assign status      = status_reg;
    assign item_out    = item_reg;
    assign found       = hit_reg;
    assign queue_empty = !any_ne;
    assign done        = done_reg;
endmodule

FILE: design/aging_priority_queue.sv
// ----------------------------------------------------------------------------
// aging_priority_queue: multilevel priority queue with aging
// Top level: handshake, age limit register, controller and datapath.
// ----------------------------------------------------------------------------
// Each item is taken when start is high and busy is low; its one result shows
// on the result ports for a single cycle with done high, and must be taken
// then, as nothing holds it. All items share one single-port item memory, so
// the block takes no new item before it is through with the last; the next
// accept may fall in the result cycle. A pop takes longer for each aged level,
// each level that promotes and each promoted item, and a contains query for
// each stored item and each level it scans. age_limit may be written only
// while idle.
module aging_priority_queue #(
    parameter int NUM_LEVELS  = 8,
    parameter int LEVEL_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [31:0] item_value,
    input  logic [3:0]  priority_req,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output logic        done,
    output logic [1:0]  status,
    output logic [31:0] item_out,
    output logic        found,
    output logic        queue_empty
);
    import apq_pkg::*;

    apq_cmd_t   cmd;
    apq_stat_t  stat;
    logic [15:0] age_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_limit_reg <= 16'd4;
        end
        else if (cfg_valid && cfg_ready)
        begin
            age_limit_reg <= cfg_data;
        end
    end
    assign cfg_ready = 1'b1;

    apq_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .operation(operation),
        .stat(stat), .cmd(cmd), .busy(busy)
    );

    apq_dp #(.NUM_LEVELS(NUM_LEVELS), .LEVEL_DEPTH(LEVEL_DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .operation(operation), .item_value(item_value), .priority_req(priority_req),
        .age_limit(age_limit_reg), .status(status), .item_out(item_out),
        .found(found), .queue_empty(queue_empty), .done(done)
    );

    // result comes only after an accepted item
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy)) else $error("done without work");
    // a result is shown only once the sequencer is back to idle
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result while busy");
    // a failed pop returns zero
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_EMPTY) |-> (item_out == '0)) else $error("empty pop data");
endmodule

FILE: verif/aging_priority_queue_tb.sv
// ----------------------------------------------------------------------------
// aging_priority_queue_tb: self-checking bench for the aging priority queue
// Drives push, pop and contains items with random gaps, models the levels,
// aging and promotion in the bench, and compares every result in order.
// ----------------------------------------------------------------------------
module aging_priority_queue_tb;
    import apq_pkg::*;

    localparam int NLEV  = 8;
    localparam int DEPTH = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] item_out;
        logic        found;
        logic        queue_empty;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  operation;
    logic [31:0] item_value;
    logic [3:0]  priority_req;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        done;
    logic [1:0]  status;
    logic [31:0] item_out;
    logic        found;
    logic        queue_empty;

    // bench copy of the queue state
    logic [31:0] lvl_mem [NLEV][DEPTH];
    int          lvl_head [NLEV];
    int          lvl_cnt [NLEV];
    logic [15:0] lvl_age [NLEV-1];
    logic [15:0] age_limit_q;

    result_t     pending_results [$];
    int          mismatches;
    int          idle_cycles;
    bit          timed_out;
    bit          gaps_on;
    logic [31:0] pushed_vals [$];   // recent push values, reused for contains hits

    aging_priority_queue #(
        .NUM_LEVELS  (NLEV),
        .LEVEL_DEPTH (DEPTH)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .item_value   (item_value),
        .priority_req (priority_req),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .done         (done),
        .status       (status),
        .item_out     (item_out),
        .found        (found),
        .queue_empty  (queue_empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void queue_reset();
        for (int i = 0; i < NLEV; i++)
        begin
            lvl_head[i] = 0;
            lvl_cnt[i]  = 0;
            if (i < NLEV - 1)
                lvl_age[i] = '0;
        end
        age_limit_q = 16'd4;
    endfunction

    function automatic void lvl_append(int lv, logic [31:0] v);
        lvl_mem[lv][(lvl_head[lv] + lvl_cnt[lv]) % DEPTH] = v;
        lvl_cnt[lv]++;
    endfunction

    function automatic logic [31:0] lvl_take(int lv);
        logic [31:0] v;
        v = lvl_mem[lv][lvl_head[lv]];
        lvl_head[lv] = (lvl_head[lv] + 1) % DEPTH;
        lvl_cnt[lv]--;
        return v;
    endfunction

    // computes the result of one item and updates the bench state
    function automatic result_t queue_predict(logic [1:0] op, logic [31:0] val,
                                              logic [3:0] pri);
        result_t r;
        int      n;
        r = '0;
        r.status = ST_OK;
        if (op == OP_PUSH)
        begin
            if (pri >= NLEV)
                r.status = ST_BAD_PRIORITY;
            else if (lvl_cnt[pri] >= DEPTH)
                r.status = ST_FULL;
            else
                lvl_append(pri, val);
        end
        else if (op == OP_POP)
        begin
            r.status = ST_EMPTY;
            for (int i = 0; i < NLEV; i++)
            begin
                if (lvl_cnt[i] != 0)
                begin
                    r.item_out = lvl_take(i);
                    r.status   = ST_OK;
                    // age from the popped level down to the second lowest
                    for (int j = i; j < NLEV - 1; j++)
                    begin
                        lvl_age[j] = lvl_age[j] + 16'd1;
                        if (lvl_age[j] >= age_limit_q)
                        begin
                            n = DEPTH - lvl_cnt[j];
                            if (lvl_cnt[j+1] < n)
                                n = lvl_cnt[j+1];
                            repeat (n) lvl_append(j, lvl_take(j + 1));
                            lvl_age[j] = '0;
                        end
                    end
                    break;
                end
            end
        end
        else if (op == OP_CONTAINS)
        begin
            for (int i = 0; i < NLEV; i++)
                for (int k = 0; k < lvl_cnt[i]; k++)
                    if (lvl_mem[i][(lvl_head[i] + k) % DEPTH] == val)
                        r.found = 1'b1;
        end
        r.queue_empty = 1'b1;
        for (int i = 0; i < NLEV; i++)
            if (lvl_cnt[i] != 0)
                r.queue_empty = 1'b0;
        return r;
    endfunction

    // result checker: done is a one-cycle strobe, sampled at the rising edge
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && done)
        begin
            got = '{status, item_out, found, queue_empty};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %h", got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: status %0d/%0d item %h/%h found %0b/%0b empty %0b/%0b",
                                 want.status, got.status, want.item_out, got.item_out,
                                 want.found, got.found, want.queue_empty, got.queue_empty);
                end
            end
        end
    end

    // watchdog: cycles with nothing accepted and no result
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("simulation failed");
            $finish;
        end
    end

    // start stays high after an accept when the next item follows at once;
    // the block is busy then, so nothing is taken twice
    task automatic send_item(logic [1:0] op, logic [31:0] val, logic [3:0] pri);
        int gap;
        gap = gaps_on ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start        <= 1'b1;
        operation    <= op;
        item_value   <= val;
        priority_req <= pri;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(queue_predict(op, val, pri));
        if (op == OP_PUSH)
            pushed_vals.push_back(val);
        if (pushed_vals.size() > 64)
            void'(pushed_vals.pop_front());
        @(negedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_age_limit(logic [15:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        age_limit_q = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        send_item(OP_POP, 32'hFFFF_FFFF, 4'hF);           // pop on empty
        send_item(OP_CONTAINS, 32'h0, 4'h0);
        send_item(OP_PUSH, 32'h1234_5678, 4'd8);          // bad priority
        send_item(OP_PUSH, 32'hFFFF_FFFF, 4'hF);
        send_item(2'd3, 32'hA5A5_A5A5, 4'h3);             // unused operation
        send_item(OP_PUSH, 32'h0000_0000, 4'd0);
        send_item(OP_PUSH, 32'hFFFF_FFFF, 4'd7);
        send_item(OP_CONTAINS, 32'hFFFF_FFFF, 4'h0);
        send_item(OP_CONTAINS, 32'h5555_5555, 4'hA);
        send_item(OP_POP, 32'h0, 4'h0);
        send_item(OP_POP, 32'h0, 4'h0);                   // lowest level popped
        // fill one level to overflow
        for (int i = 0; i <= DEPTH; i++)
            send_item(OP_PUSH, 32'hC000_0000 + i, 4'd3);
    endtask

    task automatic test_aging(logic [15:0] lim, int n);
        int r;
        write_age_limit(lim);
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
                send_item(OP_PUSH, $urandom, 4'($urandom_range(0, NLEV - 1)));
            else if (r < 80)
                send_item(OP_POP, $urandom, 4'($urandom));
            else if (r < 90 && pushed_vals.size() > 0)
                send_item(OP_CONTAINS, pushed_vals[$urandom_range(0, pushed_vals.size() - 1)],
                          4'($urandom));
            else if (r < 96)
                send_item(OP_CONTAINS, $urandom, 4'($urandom));
            else
                send_item(2'($urandom), $urandom, 4'($urandom));
        end
    endtask

    task automatic test_drain();
        // pop until empty so promotion paths run dry
        for (int i = 0; i < NLEV * DEPTH + 2; i++)
            send_item(OP_POP, $urandom, 4'($urandom));
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        operation = '0;
        item_value = '0;
        priority_req = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        mismatches = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        gaps_on = 1'b1;
        queue_reset();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_aging(16'd0, 150);
        gaps_on = 1'b0;
        test_aging(16'd1, 150);
        gaps_on = 1'b1;
        test_aging(16'hFFFF, 150);
        test_drain();
        test_aging(16'd2, 300);
        gaps_on = 1'b0;
        test_aging(16'd4, 200);
        gaps_on = 1'b1;
        test_aging(16'd7, 200);
        test_drain();

        wait_drained();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
